// ===== rtl/vdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup cache package
// Field widths, default sizes and the lookup result type shared by the block.
// ----------------------------------------------------------------------------
package vdc_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned CoordW = 32;
  localparam int unsigned PairW  = 2 * CoordW;
  localparam int unsigned NumW   = 16;
  localparam int unsigned CntW   = NumW + 1;
  localparam int unsigned SlotW  = PairW + NumW;

  localparam int unsigned RowsDefault = 4096;
  localparam int unsigned WaysDefault = 16;

  // Outcome of one row lookup.
  typedef struct packed {
    logic            hit;
    logic            error;
    logic            insert;
    logic [NumW-1:0] number;
  } match_res_t;

endpackage
`default_nettype wire

// ===== rtl/vdc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup cache channels
// Request channel (position and coordinate pair) and result channel.
// ----------------------------------------------------------------------------
interface vdc_in_if;
  logic                       valid;
  logic                       ready;
  logic [vdc_pkg::PosW-1:0]   position_index;
  logic [vdc_pkg::CoordW-1:0] coord_u;
  logic [vdc_pkg::CoordW-1:0] coord_v;

  modport source (output valid, position_index, coord_u, coord_v, input ready);
  modport sink   (input valid, position_index, coord_u, coord_v, output ready);
endinterface

interface vdc_out_if;
  logic                     valid;
  logic                     ready;
  logic [vdc_pkg::NumW-1:0] vertex_number;
  logic                     hit;
  logic                     error;

  modport source (output valid, vertex_number, hit, error, input ready);
  modport sink   (input valid, vertex_number, hit, error, output ready);
endinterface
`default_nettype wire

// ===== rtl/vertex_dedup_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex dedup cache
// Maps (position, texture pair) to a unique vertex number, one cache row per
// position index modulo ROWS, appending misses with a global counter.
// ----------------------------------------------------------------------------
//  Channel | Dir | Moves                               | Handshake
//  in_i    | in  | position_index, coord_u, coord_v    | valid / ready
//  out_o   | out | vertex_number, hit, error           | valid / ready
//
//  Each request first reads its row from the row RAM, then compares, writes
//  the row back on an insert and loads the result register.
//  Rows are read and written whole, so a request waits for the previous one
//  to finish its write-back before it is taken.
//  After reset a clearing pass writes every row to zero while in_i.ready
//  stays low.
//  A result waiting in the output register stalls the compare stage, and a
//  request in the compare stage holds in_i.ready low until it completes.
// ----------------------------------------------------------------------------
module vertex_dedup_cache #(
  parameter int unsigned ROWS = vdc_pkg::RowsDefault,
  parameter int unsigned WAYS = vdc_pkg::WaysDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vdc_in_if.sink    in_i,
  vdc_out_if.source out_o
);
  import vdc_pkg::*;

  localparam int unsigned AddrW = $clog2(ROWS);
  localparam int unsigned FillW = $clog2(WAYS + 1);
  localparam int unsigned RowW  = WAYS * SlotW + FillW;

  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             busy_q, busy_d;
  logic [AddrW-1:0] row_q;
  logic [PairW-1:0] pair_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ov_q, ov_d;
  match_res_t       res_q;

  logic             in_fire;
  logic             done;
  logic [PosW-1:0]  red;
  logic [AddrW-1:0] row_sel;
  logic [RowW-1:0]  rd_row;
  logic [RowW-1:0]  wr_row;
  match_res_t       res;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RowW-1:0]  ram_wdata;

  assign in_i.ready = !busy_q && !clr_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign done       = busy_q && (!ov_q || out_o.ready);

  // Position modulo ROWS by restoring subtraction of shifted copies, exact for positions below 256*ROWS.
  always_comb begin
    red = in_i.position_index;
    for (int k = 7; k >= 0; k--) begin
      if ((ROWS << k) < (1 << PosW)) begin
        if (red >= PosW'(ROWS << k)) begin
          red = red - PosW'(ROWS << k);
        end
      end
    end
  end

  assign row_sel = AddrW'(red);

  vdc_ram #(
    .Width (RowW),
    .Depth (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (row_sel),
    .rdata_o (rd_row)
  );

  vdc_match #(
    .Ways (WAYS)
  ) u_match (
    .row_i  (rd_row),
    .pair_i (pair_q),
    .cnt_i  (cnt_q),
    .res_o  (res),
    .row_o  (wr_row)
  );

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = done && res.insert;
      ram_waddr = row_q;
      ram_wdata = wr_row;
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(ROWS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  assign cnt_d = (done && res.insert) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    ov_d = ov_q;
    if (done) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q  <= row_sel;
      pair_q <= {in_i.coord_v, in_i.coord_u};
    end
    if (done) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.vertex_number = res_q.number;
  assign out_o.hit           = res_q.hit;
  assign out_o.error         = res_q.error;

endmodule
`default_nettype wire

// ===== rtl/vdc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vdc_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Row match and update
// Compares the pair against every used slot of a row, picks the first hit,
// and builds the updated row for an insert.
// ----------------------------------------------------------------------------
module vdc_match #(
  parameter int unsigned Ways = vdc_pkg::WaysDefault
) (
  input  wire logic [Ways*vdc_pkg::SlotW+$clog2(Ways+1)-1:0] row_i,
  input  wire logic [vdc_pkg::PairW-1:0]                     pair_i,
  input  wire logic [vdc_pkg::CntW-1:0]                      cnt_i,
  output vdc_pkg::match_res_t                                res_o,
  output logic      [Ways*vdc_pkg::SlotW+$clog2(Ways+1)-1:0] row_o
);
  import vdc_pkg::*;

  localparam int unsigned FillW = $clog2(Ways + 1);

  logic [FillW-1:0] fill;
  logic [Ways-1:0]  match;
  logic             hit;
  logic             full;
  logic             insert;
  logic [NumW-1:0]  hit_num;

  assign fill = row_i[FillW-1:0];

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      match[w] = (FillW'(w) < fill) &&
                 (row_i[FillW + w*SlotW +: PairW] == pair_i);
    end
  end

  // Walk from the top so the lowest matching slot wins.
  always_comb begin
    hit     = 1'b0;
    hit_num = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_num = row_i[FillW + w*SlotW + PairW +: NumW];
      end
    end
  end

  assign full   = (fill >= FillW'(Ways));
  assign insert = !hit && !full && !cnt_i[CntW-1];

  always_comb begin
    res_o.hit    = hit;
    res_o.insert = insert;
    res_o.error  = !hit && !insert;
    if (hit) begin
      res_o.number = hit_num;
    end else if (insert) begin
      res_o.number = cnt_i[NumW-1:0];
    end else begin
      res_o.number = '0;
    end
  end

  always_comb begin
    row_o = row_i;
    if (insert) begin
      row_o[FillW-1:0] = fill + FillW'(1);
      for (int w = 0; w < Ways; w++) begin
        if (FillW'(w) == fill) begin
          row_o[FillW + w*SlotW +: SlotW] = {cnt_i[NumW-1:0], pair_i};
        end
      end
    end
  end

endmodule
`default_nettype wire
